// ===== src/indexed_array_table_engine_defines.svh =====
// Assertion macros shared by the table engine.
`ifndef INDEXED_ARRAY_TABLE_ENGINE_DEFINES_SVH
`define INDEXED_ARRAY_TABLE_ENGINE_DEFINES_SVH

`ifndef SYNTH
`define IATE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("table engine check failed");
`define IATE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("table engine check failed");
`else
`define IATE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IATE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/iate_pkg.sv =====
`default_nettype none

package iate_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int VAL_W  = 32;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_SEARCH = 3'd2;
    localparam logic [2:0] OP_SORT   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]               func;
        logic [8:0]               position;
        logic signed [VAL_W-1:0]  item_value;
        logic                     ascending;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic                     found;
        logic signed [VAL_W-1:0]  read_value;
        logic [8:0]               entry_count;
    } t_out_item;

    // True when a must be placed after b in the requested order.
    function automatic logic after_key(input logic signed [VAL_W-1:0] a,
                                       input logic signed [VAL_W-1:0] b,
                                       input logic up);
        logic res;
        res = up ? (a > b) : (a < b);
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/iate_ram.sv =====
`default_nettype none

module iate_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/indexed_array_table_engine.sv =====
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_stall o_out_item (t_out_item)
//
// One item is worked on at a time; the entry memory has one read and one write port.
// What each item does: insert shifts the entries from the end down to the position
// up by one and then writes the value, or writes it at once at the end of the table;
// delete shifts the later entries down by one, or just drops the last entry; search
// reads from the start until a match or the end; read does one memory read; sort is
// an insertion sort, one memory step per compare; rejected or ignored items do none.
// Reset is synchronous and leaves the table empty; no clearing pass is needed.
// A result waiting on a stalled output does not block the next item from being taken.
`default_nettype none

`include "indexed_array_table_engine_defines.svh"

module indexed_array_table_engine
    import iate_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_WR,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_SORT_V,
        S_SORT_GV,
        S_SORT_CMP,
        S_SORT_PUT,
        S_READ_RD,
        S_READ_GET,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_pos;
    logic [CNT_W-1:0]        r_i;
    logic [CNT_W-1:0]        r_j;
    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] r_v;
    logic                    r_up;
    logic [1:0]              r_status;
    logic                    r_found;
    logic signed [VAL_W-1:0] r_rd;
    logic                    r_out_valid;
    t_out_item               r_out;

    t_state                  n_acc_state;
    logic [1:0]              n_acc_status;
    logic [CNT_W-1:0]        n_acc_i;
    logic [CNT_W-1:0]        n_acc_count;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;

    logic [CNT_W-1:0]        w_i_m1;
    logic [CNT_W-1:0]        w_i_m2;
    logic [CNT_W-1:0]        w_i_p1;
    logic [CNT_W-1:0]        w_i_p2;
    logic [CNT_W-1:0]        w_j_m1;
    logic [CNT_W-1:0]        w_j_m2;
    logic [CNT_W-1:0]        w_in_pos_p1;
    logic                    w_after;

    assign w_i_m1      = r_i - CNT_W'(1);
    assign w_i_m2      = r_i - CNT_W'(2);
    assign w_i_p1      = r_i + CNT_W'(1);
    assign w_i_p2      = r_i + CNT_W'(2);
    assign w_j_m1      = r_j - CNT_W'(1);
    assign w_j_m2      = r_j - CNT_W'(2);
    assign w_in_pos_p1 = i_in_item.position + CNT_W'(1);
    assign w_after     = after_key($signed(ram_rdata), r_v, r_up);

    iate_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Memory port control. Shifts overlap the read of the next entry with the
    // write of the current one; the two addresses always differ.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (r_state)
            S_INS_RD: begin
                ram_re    = 1'b1;
                ram_raddr = w_i_m1[ADDR_W-1:0];
            end
            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[ADDR_W-1:0];
                ram_wdata = ram_rdata;
                if (w_i_m1 > r_pos) begin
                    ram_re    = 1'b1;
                    ram_raddr = w_i_m2[ADDR_W-1:0];
                end
            end
            S_INS_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[ADDR_W-1:0];
                ram_wdata = r_val;
            end
            S_DEL_RD: begin
                ram_re    = 1'b1;
                ram_raddr = w_i_p1[ADDR_W-1:0];
            end
            S_DEL_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[ADDR_W-1:0];
                ram_wdata = ram_rdata;
                if (w_i_p2 < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = w_i_p2[ADDR_W-1:0];
                end
            end
            S_SRCH_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_i[ADDR_W-1:0];
            end
            S_SRCH_CHK: begin
                if (($signed(ram_rdata) != r_val) && (w_i_p1 < r_count)) begin
                    ram_re    = 1'b1;
                    ram_raddr = w_i_p1[ADDR_W-1:0];
                end
            end
            S_SORT_V: begin
                ram_re    = 1'b1;
                ram_raddr = r_i[ADDR_W-1:0];
            end
            S_SORT_GV: begin
                ram_re    = 1'b1;
                ram_raddr = w_i_m1[ADDR_W-1:0];
            end
            S_SORT_CMP: begin
                ram_we = 1'b1;
                ram_waddr = r_j[ADDR_W-1:0];
                if (w_after) begin
                    ram_wdata = ram_rdata;
                    if (r_j > CNT_W'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = w_j_m2[ADDR_W-1:0];
                    end
                end else begin
                    ram_wdata = r_v;
                end
            end
            S_SORT_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[ADDR_W-1:0];
                ram_wdata = r_v;
            end
            S_READ_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_pos[ADDR_W-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Decode of a newly offered item: first state, early status, loop start and the count for a last-entry delete.
    always_comb begin
        n_acc_state  = S_DONE;
        n_acc_status = ST_OK;
        n_acc_i      = '0;
        n_acc_count  = r_count;
        case (i_in_item.func)
            OP_INSERT: begin
                n_acc_i = r_count;
                if (i_in_item.position > r_count) begin
                    n_acc_status = ST_RANGE;
                end else if (r_count >= CNT_W'(DEPTH)) begin
                    n_acc_status = ST_FULL;
                end else if (r_count > i_in_item.position) begin
                    n_acc_state = S_INS_RD;
                end else begin
                    n_acc_state = S_INS_PUT;
                end
            end
            OP_DELETE: begin
                n_acc_i = i_in_item.position;
                if (i_in_item.position >= r_count) begin
                    n_acc_status = ST_RANGE;
                end else if (w_in_pos_p1 < r_count) begin
                    n_acc_state = S_DEL_RD;
                end else begin
                    n_acc_count = r_count - CNT_W'(1);
                end
            end
            OP_SEARCH: begin
                if (r_count != '0) begin
                    n_acc_state = S_SRCH_RD;
                end
            end
            OP_SORT: begin
                n_acc_i = CNT_W'(1);
                if (r_count >= CNT_W'(2)) begin
                    n_acc_state = S_SORT_V;
                end
            end
            OP_READ: begin
                if (i_in_item.position >= r_count) begin
                    n_acc_status = ST_RANGE;
                end else begin
                    n_acc_state = S_READ_RD;
                end
            end
            default: begin
                n_acc_state = S_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pos    <= i_in_item.position;
                        r_val    <= i_in_item.item_value;
                        r_up     <= i_in_item.ascending;
                        r_status <= n_acc_status;
                        r_found  <= 1'b0;
                        r_rd     <= '0;
                        r_i      <= n_acc_i;
                        r_count  <= n_acc_count;
                        r_state  <= n_acc_state;
                    end
                end
                S_INS_RD: begin
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    r_i <= w_i_m1;
                    if (!(w_i_m1 > r_pos)) begin
                        r_state <= S_INS_PUT;
                    end
                end
                S_INS_PUT: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_DONE;
                end
                S_DEL_RD: begin
                    r_state <= S_DEL_WR;
                end
                S_DEL_WR: begin
                    r_i <= w_i_p1;
                    if (!(w_i_p2 < r_count)) begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_DONE;
                    end
                end
                S_SRCH_RD: begin
                    r_state <= S_SRCH_CHK;
                end
                S_SRCH_CHK: begin
                    r_i <= w_i_p1;
                    if ($signed(ram_rdata) == r_val) begin
                        r_found <= 1'b1;
                        r_state <= S_DONE;
                    end else if (!(w_i_p1 < r_count)) begin
                        r_state <= S_DONE;
                    end
                end
                S_SORT_V: begin
                    r_state <= S_SORT_GV;
                end
                S_SORT_GV: begin
                    r_v     <= ram_rdata;
                    r_j     <= r_i;
                    r_state <= S_SORT_CMP;
                end
                S_SORT_CMP: begin
                    if (w_after) begin
                        // The entry below moves up; the hole reaches the bottom
                        // once the index runs down to zero.
                        r_j <= w_j_m1;
                        if (!(r_j > CNT_W'(1))) begin
                            r_state <= S_SORT_PUT;
                        end
                    end else begin
                        r_i     <= w_i_p1;
                        r_state <= (w_i_p1 < r_count) ? S_SORT_V : S_DONE;
                    end
                end
                S_SORT_PUT: begin
                    r_i     <= w_i_p1;
                    r_state <= (w_i_p1 < r_count) ? S_SORT_V : S_DONE;
                end
                S_READ_RD: begin
                    r_state <= S_READ_GET;
                end
                S_READ_GET: begin
                    r_rd    <= ram_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.status      <= r_status;
                        r_out.found       <= r_found;
                        r_out.read_value  <= r_rd;
                        r_out.entry_count <= r_count;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `IATE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `IATE_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `IATE_ASSERT_IMP(a_port_no_clash, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr)

endmodule

`default_nettype wire
